// ----- rtl/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_SP_A    = 4'd3,
        PH_SP_B    = 4'd4,
        PH_WR_SET  = 4'd5,
        PH_WR_HIGH = 4'd6,
        PH_WR_FALL = 4'd7,
        PH_AK_REL  = 4'd8,
        PH_AK_HIGH = 4'd9,
        PH_AK_POLL = 4'd10,
        PH_RD_LOW  = 4'd11,
        PH_RD_HIGH = 4'd12,
        PH_NK_SET  = 4'd13,
        PH_NK_HIGH = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    localparam logic       ACT_TICK        = 1'b0;
    localparam logic       ACT_COMMAND     = 1'b1;

    localparam logic       CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic       CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd1;
    localparam logic [9:0]  ACK_TIMEOUT_RESET    = 10'd250;
    localparam logic [3:0]  BITS_PER_BYTE        = 4'd8;

    typedef struct packed {
        logic       rejected;
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } result_t;

    function automatic logic [2:0] step_units(input phase_t ph);
        logic [2:0] units;
        case (ph)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B:                   units = 3'd4;
            PH_WR_SET, PH_WR_HIGH, PH_WR_FALL, PH_RD_LOW,
            PH_NK_SET, PH_NK_HIGH:                                units = 3'd2;
            PH_AK_REL, PH_AK_HIGH, PH_AK_POLL, PH_RD_HIGH:        units = 3'd1;
            default:                                              units = 3'd0;
        endcase
        return units;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/i2c_master_byte_engine_core.sv -----
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: command, tx_byte,
//                                               send_ack, sda_in
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: line levels, status, rx_byte
// cfg       in   cfg_we (no wait)               cfg_addr selects register, cfg_wdata
//
// One request per clock: each accepted request updates the bus engine state in the
// same cycle and its result lands in the output register on that edge.
// A pending result stalls the input only if m_axis_tready is low in that cycle.
// Reset (rst_n low, asynchronous) idles the engine with SCL and SDA high and SDA driven.
`default_nettype none

module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic        s_axis_tuser,   // action
    input  wire logic [15:0] s_axis_tdata,   // command[1:0], tx_byte[9:2], send_ack[10],
                                             // sda_in[11], zero[15:12]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                             // busy_res[3], done_res[4], rx_byte[12:5],
                                             // ack_failed[13], rejected[14], zero[15]

    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0] ticks_per_unit_reg;
    logic [9:0]  ack_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [9:0]  unit_count_reg, unit_count_next;
    logic [9:0]  wait_count_reg, wait_count_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic        ack_mode_reg, ack_mode_next;
    logic        fail_reg, fail_next;
    logic [7:0]  rx_reg, rx_next;

    logic        out_valid_reg;
    result_t     out_reg, out_next;

    logic        accept;
    logic        in_action;
    command_t    in_command;
    logic [7:0]  in_tx_byte;
    logic        in_send_ack;
    logic        in_sda;

    logic [15:0] tpu;
    logic        enter_en;
    phase_t      enter_ph;
    logic        done;
    logic        rej;
    logic [3:0]  bit_inc;
    logic [7:0]  rd_shift;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_action     = s_axis_tuser;
    assign in_command    = command_t'(s_axis_tdata[1:0]);
    assign in_tx_byte    = s_axis_tdata[9:2];
    assign in_send_ack   = s_axis_tdata[10];
    assign in_sda        = s_axis_tdata[11];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

    assign tpu      = (ticks_per_unit_reg == 16'd0) ? 16'd1 : ticks_per_unit_reg;
    assign bit_inc  = bit_count_reg + 4'd1;
    assign rd_shift = {shift_reg[6:0], in_sda};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_unit_reg <= TICKS_PER_UNIT_RESET;
            ack_timeout_reg    <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TICKS_PER_UNIT: ticks_per_unit_reg <= cfg_wdata;
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_wdata[9:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        unit_count_next = unit_count_reg;
        wait_count_next = wait_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        ack_mode_next   = ack_mode_reg;
        fail_next       = fail_reg;
        rx_next         = rx_reg;
        enter_en        = 1'b0;
        enter_ph        = PH_IDLE;
        done            = 1'b0;
        rej             = 1'b0;

        if (in_action == ACT_COMMAND)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                enter_en = 1'b1;
                case (in_command)
                    CMD_START: enter_ph = PH_ST_A;
                    CMD_STOP:  enter_ph = PH_SP_A;
                    CMD_WRITE:
                    begin
                        fail_next      = 1'b0;
                        shift_next     = in_tx_byte;
                        bit_count_next = 4'd0;
                        enter_ph       = PH_WR_SET;
                    end
                    default:
                    begin
                        ack_mode_next  = in_send_ack;
                        shift_next     = 8'd0;
                        bit_count_next = 4'd0;
                        enter_ph       = PH_RD_LOW;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_count_next = tick_count_reg + 16'd1;
            if (tick_count_next >= tpu)
            begin
                tick_count_next = 16'd0;
                unit_count_next = unit_count_reg + 10'd1;
                if (unit_count_next >= {7'd0, step_units(phase_reg)})
                begin
                    case (phase_reg)
                        PH_ST_A:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_ST_B;
                        end
                        PH_ST_B:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_SP_B;
                        end
                        PH_SP_B:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_WR_SET:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_WR_HIGH;
                        end
                        PH_WR_HIGH:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_WR_FALL;
                        end
                        PH_WR_FALL:
                        begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_inc;
                            enter_en       = 1'b1;
                            enter_ph       = (bit_inc >= BITS_PER_BYTE) ? PH_AK_REL : PH_WR_SET;
                        end
                        PH_AK_REL:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_AK_HIGH;
                        end
                        PH_AK_HIGH:
                        begin
                            if (!in_sda)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                wait_count_next = 10'd0;
                                enter_en        = 1'b1;
                                enter_ph        = PH_AK_POLL;
                            end
                        end
                        PH_AK_POLL:
                        begin
                            if (wait_count_reg >= ack_timeout_reg)
                            begin
                                fail_next = 1'b1;
                                enter_en  = 1'b1;
                                enter_ph  = PH_SP_A;
                            end
                            else if (!in_sda)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                wait_count_next = wait_count_reg + 10'd1;
                                enter_en        = 1'b1;
                                enter_ph        = PH_AK_POLL;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_RD_HIGH;
                        end
                        PH_RD_HIGH:
                        begin
                            shift_next     = rd_shift;
                            bit_count_next = bit_inc;
                            enter_en       = 1'b1;
                            if (bit_inc >= BITS_PER_BYTE)
                            begin
                                rx_next  = rd_shift;
                                enter_ph = PH_NK_SET;
                            end
                            else
                            begin
                                enter_ph = PH_RD_LOW;
                            end
                        end
                        PH_NK_SET:
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_NK_HIGH;
                        end
                        PH_NK_HIGH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        // apply the line levels of the step being entered
        if (enter_en)
        begin
            phase_next      = enter_ph;
            tick_count_next = 16'd0;
            unit_count_next = 10'd0;
            case (enter_ph)
                PH_ST_A:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                PH_ST_B:    sda_next = 1'b0;
                PH_SP_A:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                PH_SP_B:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_WR_SET:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = shift_next[7];
                end
                PH_WR_HIGH: scl_next = 1'b1;
                PH_WR_FALL: scl_next = 1'b0;
                PH_AK_REL:
                begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                end
                PH_AK_HIGH: scl_next = 1'b1;
                PH_RD_LOW:
                begin
                    drive_next = 1'b0;
                    scl_next   = 1'b0;
                end
                PH_RD_HIGH: scl_next = 1'b1;
                PH_NK_SET:
                begin
                    scl_next   = 1'b0;
                    drive_next = 1'b1;
                    sda_next   = !ack_mode_next;
                end
                PH_NK_HIGH: scl_next = 1'b1;
                default:    ;
            endcase
        end

        out_next.scl_level  = scl_next;
        out_next.sda_level  = sda_next;
        out_next.sda_drive  = drive_next;
        out_next.busy_res   = (phase_next != PH_IDLE);
        out_next.done_res   = done;
        out_next.rx_byte    = rx_next;
        out_next.ack_failed = fail_next;
        out_next.rejected   = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            tick_count_reg <= 16'd0;
            unit_count_reg <= 10'd0;
            wait_count_reg <= 10'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b1;
            ack_mode_reg   <= 1'b0;
            fail_reg       <= 1'b0;
            rx_reg         <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            unit_count_reg <= unit_count_next;
            wait_count_reg <= wait_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drive_reg      <= drive_next;
            ack_mode_reg   <= ack_mode_next;
            fail_reg       <= fail_next;
            rx_reg         <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rejected |-> out_reg.busy_res)
        else $error("reject reported while engine idle");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done_res |-> !out_reg.busy_res)
        else $error("done reported while still busy");

    a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_count_reg == 16'd0)
        else $error("timing counters left running in idle");

    a_release_phases: assert property (@(posedge clk) disable iff (!rst_n)
        !drive_reg |-> phase_reg == PH_AK_REL || phase_reg == PH_AK_HIGH
            || phase_reg == PH_AK_POLL || phase_reg == PH_RD_LOW
            || phase_reg == PH_RD_HIGH || phase_reg == PH_IDLE)
        else $error("SDA released outside a receive step");

    a_result_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_reg.busy_res == (phase_reg != PH_IDLE) && out_reg.scl_level == scl_reg)
        else $error("result register out of step with engine state");

endmodule

`default_nettype wire
